### src/vending_purchase_with_change_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vending purchase unit
// Clocked property checks that switch off together when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef VENDING_PURCHASE_WITH_CHANGE_UNIT_DEFINES_SVH
`define VENDING_PURCHASE_WITH_CHANGE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Implication checked in the same cycle, quiet during reset.
`define VPWC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VPWC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VPWC_ASSERT(name, prop, msg)
`define VPWC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### src/vpwc_pkg.sv
// ----------------------------------------------------------------------------
// Vending purchase unit package
// Widths, request and status codes, coin tables and the types shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package vpwc_pkg;

  localparam int MAX_SLOTS = 26;
  localparam int NUM_COINS = 6;

  localparam int SLOT_W   = 5;
  localparam int IDX_W    = 3;
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 8;
  localparam int INS_W    = 8;
  localparam int PRICE_W  = 16;
  localparam int STOCK_W  = 8;
  localparam int BOX_W    = 16;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 17;
  localparam int REM_W    = 17;
  localparam int VAL_W    = 8;
  localparam int PAY_W    = BOX_W + VAL_W;

  // Division by a coin value is a multiply by a scaled reciprocal. With a
  // 25-bit scale the quotient is exact for every remainder below 2**17.
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;
  localparam int RECIP_W     = 23;
  localparam int PROD_W      = REM_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 2;
  localparam logic [PADDR_W-1:0] ADDR_SLOTS = 2'd0;
  localparam logic [SLOT_W-1:0]  SLOTS_RESET = 5'd26;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_PURCHASE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_SLOT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_BOX  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_SOLD      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SOLD_OUT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd5;

  localparam logic [KEY_W-1:0] KEY_UPPER_A = 8'h41;
  localparam logic [KEY_W-1:0] KEY_UPPER_Z = 8'h5a;
  localparam logic [KEY_W-1:0] KEY_LOWER_A = 8'h61;
  localparam logic [KEY_W-1:0] CASE_OFFSET = 8'h20;

  // Index 0 is the two euro coin, index 5 the five cent coin.
  localparam logic [NUM_COINS-1:0][VAL_W-1:0] COIN_VALUE =
    {8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200};

  localparam logic [NUM_COINS-1:0][RECIP_W-1:0] COIN_RECIP = {
    RECIP_W'((RECIP_ONE + 4) / 5),
    RECIP_W'((RECIP_ONE + 9) / 10),
    RECIP_W'((RECIP_ONE + 19) / 20),
    RECIP_W'((RECIP_ONE + 49) / 50),
    RECIP_W'((RECIP_ONE + 99) / 100),
    RECIP_W'((RECIP_ONE + 199) / 200)
  };

  typedef struct packed {
    logic [REQ_W-1:0]                  req_type;
    logic [KEY_W-1:0]                  slot_key;
    logic [NUM_COINS-1:0][INS_W-1:0]   coins;
    logic [PRICE_W-1:0]                load_price_cents;
    logic [STOCK_W-1:0]                load_stock;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]               status;
    logic [NUM_COINS-1:0][BOX_W-1:0]   coins;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic eval;
    logic div;
    logic pay;
    logic settle;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go;
    logic last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### src/vpwc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one purchase or load request.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpwc_req_if;
  import vpwc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [KEY_W-1:0]     slot_key;
  logic [INS_W-1:0]     coins_two_euro;
  logic [INS_W-1:0]     coins_one_euro;
  logic [INS_W-1:0]     coins_fifty_cent;
  logic [INS_W-1:0]     coins_twenty_cent;
  logic [INS_W-1:0]     coins_ten_cent;
  logic [INS_W-1:0]     coins_five_cent;
  logic [PRICE_W-1:0]   load_price_cents;
  logic [STOCK_W-1:0]   load_stock;

  modport source (
    output valid, req_type, slot_key, coins_two_euro, coins_one_euro,
           coins_fifty_cent, coins_twenty_cent, coins_ten_cent, coins_five_cent,
           load_price_cents, load_stock,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot_key, coins_two_euro, coins_one_euro,
           coins_fifty_cent, coins_twenty_cent, coins_ten_cent, coins_five_cent,
           load_price_cents, load_stock,
    output ready
  );
endinterface

`default_nettype wire

### src/vpwc_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the status and coin counts of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpwc_rsp_if;
  import vpwc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [BOX_W-1:0]     out_two_euro;
  logic [BOX_W-1:0]     out_one_euro;
  logic [BOX_W-1:0]     out_fifty_cent;
  logic [BOX_W-1:0]     out_twenty_cent;
  logic [BOX_W-1:0]     out_ten_cent;
  logic [BOX_W-1:0]     out_five_cent;

  modport source (
    output valid, status, out_two_euro, out_one_euro, out_fifty_cent,
           out_twenty_cent, out_ten_cent, out_five_cent,
    input  ready
  );

  modport sink (
    input  valid, status, out_two_euro, out_one_euro, out_fifty_cent,
           out_twenty_cent, out_ten_cent, out_five_cent,
    output ready
  );
endinterface

`default_nettype wire

### src/vpwc_datapath.sv
// ----------------------------------------------------------------------------
// Vending purchase datapath
// Slot tables, coin box, slot decode, total, greedy change arithmetic and the
// result register, stepped by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vending_purchase_with_change_unit_defines.svh"

module vpwc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  vpwc_pkg::req_t            in_data,
  input  vpwc_pkg::ctrl_cmd_t       cmd,
  output vpwc_pkg::ctrl_sts_t       sts,
  input  logic                      cfg_we,
  input  logic [vpwc_pkg::SLOT_W-1:0] cfg_value,
  output logic [vpwc_pkg::SLOT_W-1:0] slots,
  output vpwc_pkg::rsp_t            out_data,
  output logic                      out_valid,
  input  logic                      out_ready
);
  import vpwc_pkg::*;

  logic [PRICE_W-1:0] price_table [MAX_SLOTS];
  logic [STOCK_W-1:0] stock_table [MAX_SLOTS];
  logic [BOX_W-1:0]   box  [NUM_COINS];
  logic [BOX_W-1:0]   work [NUM_COINS];
  logic [BOX_W-1:0]   paid [NUM_COINS];

  req_t               req_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               slot_ok_q;
  logic [TOTAL_W-1:0] total_q;
  logic [PRICE_W-1:0] price_q;
  logic [STOCK_W-1:0] stock_q;
  logic [STATUS_W-1:0] code_q;
  logic [REM_W-1:0]   rem_q;
  logic [Q_W-1:0]     q_q;
  logic [IDX_W-1:0]   idx_q;

  logic [KEY_W-1:0]   key_fold;
  logic [KEY_W-1:0]   key_off;
  logic [SLOT_W-1:0]  slot_limit;
  logic               dec_ok;
  logic [SLOT_W-1:0]  dec_slot;
  logic [TOTAL_W-1:0] sum;
  logic [STATUS_W-1:0] verdict;
  logic               go;
  logic [PROD_W-1:0]  div_prod;
  logic [BOX_W-1:0]   pay_n;
  logic [PAY_W-1:0]   pay_amt;
  logic               rem_zero;
  logic               load_req;

  // Key decode: upper case folds to lower case, 'a' is slot zero.
  always_comb begin
    key_fold = in_data.slot_key;
    if (in_data.slot_key >= KEY_UPPER_A && in_data.slot_key <= KEY_UPPER_Z) begin
      key_fold = in_data.slot_key + CASE_OFFSET;
    end
    slot_limit = (slots > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : slots;
    key_off    = key_fold - KEY_LOWER_A;
    dec_ok     = (key_fold >= KEY_LOWER_A) && (key_off < KEY_W'(slot_limit));
    dec_slot   = dec_ok ? key_off[SLOT_W-1:0] : '0;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_COINS; i++) begin
      sum = sum + TOTAL_W'(req_q.coins[i]) * TOTAL_W'(COIN_VALUE[i]);
    end
  end

  always_comb begin
    go = 1'b0;
    priority if (req_q.req_type == REQ_LOAD_SLOT) begin
      verdict = slot_ok_q ? ST_LOADED : ST_INVALID;
    end else if (req_q.req_type == REQ_LOAD_BOX) begin
      verdict = ST_LOADED;
    end else if (req_q.req_type != REQ_PURCHASE || !slot_ok_q) begin
      verdict = ST_INVALID;
    end else if (stock_q == '0) begin
      verdict = ST_SOLD_OUT;
    end else if (total_q < TOTAL_W'(price_q)) begin
      verdict = ST_SHORT;
    end else begin
      verdict = ST_NO_CHANGE;
      go      = 1'b1;
    end
  end

  assign div_prod = PROD_W'(rem_q) * PROD_W'(COIN_RECIP[idx_q]);
  assign pay_n    = (BOX_W'(q_q) < work[idx_q]) ? BOX_W'(q_q) : work[idx_q];
  assign pay_amt  = PAY_W'(pay_n) * PAY_W'(COIN_VALUE[idx_q]);
  assign rem_zero = (rem_q == '0);
  assign load_req = (req_q.req_type == REQ_LOAD_SLOT) || (req_q.req_type == REQ_LOAD_BOX);

  assign sts.go       = go;
  assign sts.last     = (idx_q == IDX_W'(NUM_COINS - 1));
  assign sts.out_busy = out_valid && !out_ready;

  // Architectural state: configuration, slot tables and the coin box.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= SLOTS_RESET;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        price_table[s] <= '0;
        stock_table[s] <= '0;
      end
      for (int i = 0; i < NUM_COINS; i++) begin
        box[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        slots <= cfg_value;
      end
      if (cmd.eval) begin
        if (req_q.req_type == REQ_LOAD_SLOT && slot_ok_q) begin
          price_table[slot_q] <= req_q.load_price_cents;
          stock_table[slot_q] <= req_q.load_stock;
        end
        if (req_q.req_type == REQ_LOAD_BOX) begin
          for (int i = 0; i < NUM_COINS; i++) begin
            box[i] <= BOX_W'(req_q.coins[i]);
          end
        end
      end
      // The working copy is committed only when the change came out exact,
      // so a failed sale leaves the box as it was.
      if (cmd.settle && rem_zero) begin
        for (int i = 0; i < NUM_COINS; i++) begin
          box[i] <= work[i] - paid[i];
        end
        stock_table[slot_q] <= stock_q - STOCK_W'(1);
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= in_data;
      slot_q    <= dec_slot;
      slot_ok_q <= dec_ok;
    end
    if (cmd.fetch) begin
      total_q <= sum;
      price_q <= price_table[slot_q];
      stock_q <= stock_table[slot_q];
    end
    if (cmd.eval) begin
      code_q <= verdict;
      rem_q  <= REM_W'(total_q - TOTAL_W'(price_q));
      idx_q  <= '0;
      for (int i = 0; i < NUM_COINS; i++) begin
        if ((BOX_W + 1)'(box[i]) + (BOX_W + 1)'(req_q.coins[i]) > (BOX_W + 1)'({BOX_W{1'b1}})) begin
          work[i] <= {BOX_W{1'b1}};
        end else begin
          work[i] <= box[i] + BOX_W'(req_q.coins[i]);
        end
      end
    end
    if (cmd.div) begin
      q_q <= div_prod[RECIP_SHIFT +: Q_W];
    end
    if (cmd.pay) begin
      paid[idx_q] <= pay_n;
      rem_q       <= rem_q - pay_amt[REM_W-1:0];
      idx_q       <= idx_q + IDX_W'(1);
    end
    if (cmd.settle) begin
      code_q <= rem_zero ? ST_SOLD : ST_NO_CHANGE;
    end
    if (cmd.load_out) begin
      out_data.status <= code_q;
      for (int i = 0; i < NUM_COINS; i++) begin
        if (code_q == ST_SOLD) begin
          out_data.coins[i] <= paid[i];
        end else if (load_req) begin
          out_data.coins[i] <= '0;
        end else begin
          out_data.coins[i] <= BOX_W'(req_q.coins[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `VPWC_ASSERT(a_out_free, cmd.load_out |-> !(out_valid && !out_ready), "result register overwritten before it was taken")
  `VPWC_ASSERT_NEXT(a_out_shown, cmd.load_out, out_valid, "loaded result not presented")
  `VPWC_ASSERT(a_idx_range, (cmd.div || cmd.pay) |-> (idx_q < IDX_W'(NUM_COINS)), "coin index out of range")
  `VPWC_ASSERT(a_sale_stock, (cmd.settle && rem_zero) |-> (stock_q != '0), "sale from an empty slot")

endmodule

`default_nettype wire

### src/vpwc_ctrl.sv
// ----------------------------------------------------------------------------
// Vending purchase controller
// Sequences capture, fetch, evaluation, the six coin change steps, settling and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vpwc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vpwc_pkg::ctrl_sts_t  sts,
  output vpwc_pkg::ctrl_cmd_t  cmd
);
  import vpwc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PAY    = 3'd4;
  localparam logic [2:0] S_SETTLE = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        // No transaction is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.go ? S_DIV : S_RESULT;
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_PAY;
      end
      S_PAY: begin
        cmd.pay    = 1'b1;
        state_next = sts.last ? S_SETTLE : S_DIV;
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // Wait here only while the previous result is still unclaimed.
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/vending_purchase_with_change_unit.sv
// ----------------------------------------------------------------------------
// Vending purchase unit with greedy change
// Top level: request and result channels, APB register port, controller and
// datapath.
// ----------------------------------------------------------------------------
// Each request yields one result. Purchases that pass the key, stock and
// money checks step through capture, slot fetch and evaluation, then for
// each of the six coin kinds a reciprocal multiply for the quotient and a
// pay step, both through arithmetic shared by all coin kinds, then settle
// and a load of the result register. Loads and refused purchases go from
// evaluation straight to the result load. A finished result sits in its
// own register, so the next request is taken while it waits; the block
// only stalls when a second result is ready before the first has been
// taken. Register slots lives at APB address 0 and resets to 26; the slot
// tables and coin box reset to zero.
`default_nettype none

module vending_purchase_with_change_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vpwc_pkg::PADDR_W-1:0]    paddr,
  input  logic [vpwc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vpwc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  vpwc_req_if.sink                        req,
  vpwc_rsp_if.source                      rsp
);
  import vpwc_pkg::*;

  req_t              in_data;
  rsp_t              out_data;
  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;
  logic              in_ready;
  logic              out_valid;
  logic              cfg_we;
  logic [SLOT_W-1:0] slots;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == ADDR_SLOTS);
  assign prdata = (paddr == ADDR_SLOTS) ? APB_DATA_W'(slots) : '0;

  assign in_data.req_type         = req.req_type;
  assign in_data.slot_key         = req.slot_key;
  assign in_data.coins[0]         = req.coins_two_euro;
  assign in_data.coins[1]         = req.coins_one_euro;
  assign in_data.coins[2]         = req.coins_fifty_cent;
  assign in_data.coins[3]         = req.coins_twenty_cent;
  assign in_data.coins[4]         = req.coins_ten_cent;
  assign in_data.coins[5]         = req.coins_five_cent;
  assign in_data.load_price_cents = req.load_price_cents;
  assign in_data.load_stock       = req.load_stock;
  assign req.ready                = in_ready;

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_data.status;
  assign rsp.out_two_euro    = out_data.coins[0];
  assign rsp.out_one_euro    = out_data.coins[1];
  assign rsp.out_fifty_cent  = out_data.coins[2];
  assign rsp.out_twenty_cent = out_data.coins[3];
  assign rsp.out_ten_cent    = out_data.coins[4];
  assign rsp.out_five_cent   = out_data.coins[5];

  vpwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vpwc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_value (pwdata[SLOT_W-1:0]),
    .slots     (slots),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (rsp.ready)
  );

endmodule

`default_nettype wire
